// ===== hdl/idsd_pkg.sv =====
// Shared types, constants and helper functions for the ILDA stream decoder.
// Used by the parser, palette memory, top level and testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package idsd_pkg;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_EOF     = 2'd1,
    KIND_BAD_SIG = 2'd2,
    KIND_BAD_FMT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_HEADER  = 2'd0,
    PHASE_POINTS  = 2'd1,
    PHASE_PALETTE = 2'd2
  } phase_t;

  localparam logic [2:0] FMT_3D_INDEXED = 3'd0;
  localparam logic [2:0] FMT_2D_INDEXED = 3'd1;
  localparam logic [2:0] FMT_PALETTE    = 3'd2;
  localparam logic [2:0] FMT_3D_TRUE    = 3'd4;
  localparam logic [2:0] FMT_2D_TRUE    = 3'd5;

  localparam int          HDR_LAST     = 31;
  localparam int          REC_REGS     = 9;
  localparam logic [8:0]  PAL_ENTRIES  = 9'd256;
  localparam logic [23:0] WHITE        = 24'hFFFFFF;
  localparam logic [7:0]  SIGNATURE [4] = '{8'h49, 8'h4C, 8'h44, 8'h41};

  localparam logic [23:0] DEFAULT_PALETTE [64] = '{
    24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000,
    24'hFF4000, 24'hFF5000, 24'hFF6000, 24'hFF7000,
    24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000,
    24'hFFC000, 24'hFFD000, 24'hFFE000, 24'hFFF000,
    24'hFFFF00, 24'hE0FF00, 24'hC0FF00, 24'hA0FF00,
    24'h80FF00, 24'h60FF00, 24'h40FF00, 24'h20FF00,
    24'h00FF00, 24'h00FF24, 24'h00FF49, 24'h00FF6D,
    24'h00FF92, 24'h00FFB6, 24'h00FFDB, 24'h00FFFF,
    24'h00E3FF, 24'h00C6FF, 24'h00AAFF, 24'h008EFF,
    24'h0071FF, 24'h0055FF, 24'h0038FF, 24'h001CFF,
    24'h0000FF, 24'h2000FF, 24'h4000FF, 24'h6000FF,
    24'h8000FF, 24'hA000FF, 24'hC000FF, 24'hE000FF,
    24'hFF00FF, 24'hFF20FF, 24'hFF40FF, 24'hFF60FF,
    24'hFF80FF, 24'hFFA0FF, 24'hFFC0FF, 24'hFFE0FF,
    24'hFFFFFF, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0,
    24'hFF8080, 24'hFF6060, 24'hFF4040, 24'hFF2020
  };

  typedef struct packed {
    kind_t       kind;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic        blank;
    logic        indexed;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } point_t;

  function automatic logic [4:0] record_size(input logic [2:0] fmt);
    logic [4:0] size;
    unique case (fmt)
      FMT_3D_INDEXED: size = 5'd8;
      FMT_2D_INDEXED: size = 5'd6;
      FMT_PALETTE:    size = 5'd3;
      FMT_3D_TRUE:    size = 5'd10;
      default:        size = 5'd8;
    endcase
    return size;
  endfunction

  // divide by 16, round half away from zero, recenter, clamp
  function automatic logic [11:0] convert_coord(input logic [15:0] raw);
    logic [16:0] mag;
    logic [12:0] q;
    logic [12:0] r;
    mag = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
    q   = 13'((mag + 17'd8) >> 4);
    r   = raw[15] ? (13'd2048 - q) : (13'd2048 + q);
    return r[12] ? 12'd4095 : r[11:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/idsd_in_if.sv =====
// Input channel of the ILDA stream decoder: one file byte per item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface idsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/idsd_out_if.sv =====
// Output channel of the ILDA stream decoder: one decoded point or status item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface idsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  intensity;
  logic        last_in_section;
  modport source (output valid, output kind, output x_pos, output y_pos, output red,
                  output green, output blue, output intensity, output last_in_section,
                  input ready);
  modport sink (input valid, input kind, input x_pos, input y_pos, input red,
                input green, input blue, input intensity, input last_in_section,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/idsd_parse.sv =====
// Byte parser: header fields, record assembly, palette writes and point stage register.
// Depends on idsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idsd_parse #(
  parameter int PROJECTORS = 4,
  parameter int SW = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              adv,
  input  wire logic [7:0]        data_byte,
  output idsd_pkg::point_t       s1,
  output logic                   s1_valid,
  output logic                   wr_en,
  output logic [SW-1:0]          slot,
  output logic [7:0]             wr_idx,
  output logic [23:0]            wr_color,
  output logic [7:0]             rd_idx
);

  localparam int         RECIP = 65536 / PROJECTORS;
  localparam logic [8:0] PW    = 9'(PROJECTORS);

  idsd_pkg::phase_t phase;
  logic [4:0]  byte_index;
  logic [2:0]  fmt;
  logic        fmt_known;
  logic [15:0] records_left;
  logic [8:0]  palette_index;
  logic        signature_ok;
  logic        halted;
  logic [7:0]  record_bytes [idsd_pkg::REC_REGS];

  logic [24:0] prod;
  logic [17:0] qp;
  logic [8:0]  rem0;
  logic [8:0]  rem1;
  logic        rec_done;
  idsd_pkg::point_t pt;
  logic        emit;

  assign prod = {9'd0, data_byte} * 17'(RECIP);
  assign qp   = prod[24:16] * PW;
  assign rem0 = {1'b0, data_byte} - qp[8:0];
  assign rem1 = (rem0 >= PW) ? (rem0 - PW) : rem0;

  assign rec_done = (byte_index + 5'd1) == idsd_pkg::record_size(fmt);
  assign rd_idx   = data_byte;
  assign wr_idx   = palette_index[7:0];
  assign wr_color = {record_bytes[0], record_bytes[1], data_byte};
  assign wr_en    = accept && !halted && phase == idsd_pkg::PHASE_PALETTE && rec_done
                    && palette_index < idsd_pkg::PAL_ENTRIES;

  always_comb begin
    pt       = '0;
    pt.kind  = idsd_pkg::KIND_POINT;
    pt.blank = 1'b1;
    emit     = 1'b0;
    if (accept && !halted) begin
      if (phase == idsd_pkg::PHASE_HEADER) begin
        if (byte_index == 5'(idsd_pkg::HDR_LAST)) begin
          priority if (!signature_ok) begin
            pt.kind = idsd_pkg::KIND_BAD_SIG;
            emit    = 1'b1;
          end else if (records_left == 16'd0) begin
            pt.kind = idsd_pkg::KIND_EOF;
            emit    = 1'b1;
          end else if (!fmt_known) begin
            pt.kind = idsd_pkg::KIND_BAD_FMT;
            emit    = 1'b1;
          end
        end
      end else if (phase == idsd_pkg::PHASE_POINTS && rec_done) begin
        emit     = 1'b1;
        pt.x_pos = idsd_pkg::convert_coord({record_bytes[0], record_bytes[1]});
        pt.y_pos = idsd_pkg::convert_coord({record_bytes[2], record_bytes[3]});
        pt.last  = records_left == 16'd1;
        unique case (fmt)
          idsd_pkg::FMT_3D_INDEXED: begin
            pt.blank   = record_bytes[6][6];
            pt.indexed = 1'b1;
          end
          idsd_pkg::FMT_2D_INDEXED: begin
            pt.blank   = record_bytes[4][6];
            pt.indexed = 1'b1;
          end
          idsd_pkg::FMT_3D_TRUE: begin
            pt.blank = record_bytes[6][6];
            pt.blue  = record_bytes[7];
            pt.green = record_bytes[8];
            pt.red   = data_byte;
          end
          default: begin
            pt.blank = record_bytes[4][6];
            pt.blue  = record_bytes[5];
            pt.green = record_bytes[6];
            pt.red   = data_byte;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= emit;
    end
    if (adv) begin
      s1 <= pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= idsd_pkg::PHASE_HEADER;
      byte_index    <= 5'd0;
      fmt           <= 3'd0;
      fmt_known     <= 1'b0;
      records_left  <= 16'd0;
      palette_index <= 9'd0;
      slot          <= '0;
      signature_ok  <= 1'b1;
      halted        <= 1'b0;
    end else if (accept && !halted) begin
      if (phase == idsd_pkg::PHASE_HEADER) begin
        if (byte_index < 5'd4 && data_byte != idsd_pkg::SIGNATURE[byte_index[1:0]]) begin
          signature_ok <= 1'b0;
        end
        if (byte_index == 5'd7) begin
          fmt       <= data_byte[2:0];
          fmt_known <= data_byte == 8'd0 || data_byte == 8'd1 || data_byte == 8'd2
                       || data_byte == 8'd4 || data_byte == 8'd5;
        end
        if (byte_index == 5'd24) records_left[15:8] <= data_byte;
        if (byte_index == 5'd25) records_left[7:0] <= data_byte;
        if (byte_index == 5'd30) slot <= SW'(rem1);
        if (byte_index != 5'(idsd_pkg::HDR_LAST)) begin
          byte_index <= byte_index + 5'd1;
        end else begin
          byte_index <= 5'd0;
          priority if (!signature_ok) begin
            halted <= 1'b1;
          end else if (records_left == 16'd0) begin
            signature_ok <= 1'b1;
          end else if (!fmt_known) begin
            halted <= 1'b1;
          end else begin
            palette_index <= 9'd0;
            phase <= (fmt == idsd_pkg::FMT_PALETTE) ? idsd_pkg::PHASE_PALETTE
                                                    : idsd_pkg::PHASE_POINTS;
          end
        end
      end else if (rec_done) begin
        byte_index   <= 5'd0;
        records_left <= records_left - 16'd1;
        if (records_left == 16'd1) phase <= idsd_pkg::PHASE_HEADER;
        if (wr_en) palette_index <= palette_index + 9'd1;
      end else begin
        byte_index <= byte_index + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !halted && phase != idsd_pkg::PHASE_HEADER
        && byte_index < 5'(idsd_pkg::REC_REGS)) begin
      record_bytes[byte_index[3:0]] <= data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/idsd_pal.sv =====
// Per-projector palette memory with a clearing pass that loads the default colors, white above the first 64.
// Depends on idsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idsd_pal #(
  parameter int PROJECTORS = 4,
  parameter int SW = 2,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [SW-1:0] slot,
  input  wire logic [7:0]    wr_idx,
  input  wire logic [23:0]   wr_color,
  input  wire logic          rd_en,
  input  wire logic [7:0]    rd_idx,
  output logic [23:0]        rd_color,
  output logic               busy
);

  localparam int DEPTH = PROJECTORS * 256;

  logic [23:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [23:0]   clr_color;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign clr_color = (clr_addr[7:6] == 2'd0) ? idsd_pkg::DEFAULT_PALETTE[clr_addr[5:0]]
                                             : idsd_pkg::WHITE;
  assign wr_addr = AW'({slot, wr_idx});
  assign rd_addr = AW'({slot, rd_idx});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= clr_color;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_color;
    end
    if (rd_en) begin
      rd_color <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ilda_stream_decoder_top.sv =====
// Top level of the ILDA stream decoder: parser, palette memory and output register.
// Depends on idsd_pkg, idsd_in_if, idsd_out_if, idsd_parse and idsd_pal.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ILDA file byte per clock and gives out decoded points, end-of-file
// and error items. After reset the palette memory is loaded with the default
// colors, during which no byte is taken. After that a byte is taken every cycle
// the output is free or being read; a result passes from the parser's stage
// register, beside the palette read register, to the output register. After a
// bad signature or unknown format the block drops all bytes until reset.
module ilda_stream_decoder_top #(
  parameter int PROJECTORS = 4
) (
  input wire logic   clk,
  input wire logic   rst,
  idsd_in_if.sink    in_ch,
  idsd_out_if.source out_ch
);

  localparam int SW = (PROJECTORS > 1) ? $clog2(PROJECTORS) : 1;
  localparam int AW = $clog2(PROJECTORS * 256);

  logic adv;
  logic accept;
  logic busy;
  idsd_pkg::point_t s1;
  logic s1_valid;
  logic wr_en;
  logic [SW-1:0] slot;
  logic [7:0] wr_idx;
  logic [23:0] wr_color;
  logic [7:0] rd_idx;
  logic [23:0] rd_color;
  logic [7:0] r, g, b, m;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv && !busy;
  assign accept      = in_ch.valid && in_ch.ready;

  idsd_parse #(.PROJECTORS(PROJECTORS), .SW(SW)) u_parse (
    .clk(clk), .rst(rst), .accept(accept), .adv(adv), .data_byte(in_ch.data_byte),
    .s1(s1), .s1_valid(s1_valid), .wr_en(wr_en), .slot(slot), .wr_idx(wr_idx),
    .wr_color(wr_color), .rd_idx(rd_idx)
  );

  idsd_pal #(.PROJECTORS(PROJECTORS), .SW(SW), .AW(AW)) u_pal (
    .clk(clk), .rst(rst), .wr_en(wr_en), .slot(slot), .wr_idx(wr_idx),
    .wr_color(wr_color), .rd_en(adv), .rd_idx(rd_idx), .rd_color(rd_color), .busy(busy)
  );

  always_comb begin
    if (s1.blank) begin
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
    end else if (s1.indexed) begin
      r = rd_color[23:16];
      g = rd_color[15:8];
      b = rd_color[7:0];
    end else begin
      r = s1.red;
      g = s1.green;
      b = s1.blue;
    end
    m = (r > g) ? r : g;
    if (b > m) m = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= s1_valid;
    end
    if (adv) begin
      out_ch.kind            <= s1.kind;
      out_ch.x_pos           <= s1.x_pos;
      out_ch.y_pos           <= s1.y_pos;
      out_ch.red             <= r;
      out_ch.green           <= g;
      out_ch.blue            <= b;
      out_ch.intensity       <= m;
      out_ch.last_in_section <= s1.last;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("byte taken during palette clear");
  a_status_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind != idsd_pkg::KIND_POINT |->
      out_ch.x_pos == 12'd0 && out_ch.intensity == 8'd0 && !out_ch.last_in_section)
    else $error("status item carries point fields");
  a_halt_after_error: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && (out_ch.kind == idsd_pkg::KIND_BAD_SIG
      || out_ch.kind == idsd_pkg::KIND_BAD_FMT) |=> !out_ch.valid)
    else $error("item after error");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_ilda_stream_decoder_top.sv =====
// Testbench for ilda_stream_decoder_top: drives ILDA file bytes, predicts the decoded
// items and checks each one. Depends on idsd_pkg, idsd_in_if, idsd_out_if and the RTL.
`timescale 1ns / 1ps
module tb_ilda_stream_decoder_top;

  localparam int NPROJ = 4;

  typedef struct packed {
    idsd_pkg::kind_t kind;
    logic [11:0]     x_pos;
    logic [11:0]     y_pos;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      intensity;
    logic            last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  idsd_in_if  in_ch ();
  idsd_out_if out_ch ();

  ilda_stream_decoder_top #(.PROJECTORS(NPROJ)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // decoder state mirror
  idsd_pkg::phase_t m_phase;
  int          m_idx;
  logic [2:0]  m_fmt;
  logic        m_fmt_known;
  logic [15:0] m_left;
  int          m_pal_idx;
  int          m_slot;
  logic        m_sig_ok;
  logic        m_halted;
  logic [7:0]  m_rec [10];
  logic [23:0] m_palette [NPROJ*256];

  decoded_t pending_items [$];
  int       errors = 0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_cycles = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [11:0] to_screen(input logic [7:0] hi, input logic [7:0] lo);
    int v;
    int q;
    int r;
    v = $signed({hi, lo});
    q = (v >= 0) ? (v + 8) / 16 : -((-v + 8) / 16);
    r = q + 2048;
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    return r[11:0];
  endfunction

  function automatic int record_size_of(input logic [2:0] f);
    case (f)
      idsd_pkg::FMT_3D_INDEXED: return 8;
      idsd_pkg::FMT_2D_INDEXED: return 6;
      idsd_pkg::FMT_PALETTE:    return 3;
      idsd_pkg::FMT_3D_TRUE:    return 10;
      default:                  return 8;
    endcase
  endfunction

  function automatic void reset_mirror();
    m_phase = idsd_pkg::PHASE_HEADER;
    m_idx = 0;
    m_fmt = 3'd0;
    m_fmt_known = 1'b0;
    m_left = 16'd0;
    m_pal_idx = 0;
    m_slot = 0;
    m_sig_ok = 1'b1;
    m_halted = 1'b0;
    foreach (m_rec[i]) m_rec[i] = 8'd0;
    for (int p = 0; p < NPROJ; p++)
      for (int i = 0; i < 256; i++)
        m_palette[p*256+i] = (i < 64) ? idsd_pkg::DEFAULT_PALETTE[i] : idsd_pkg::WHITE;
  endfunction

  function automatic void enqueue_item(input decoded_t d);
    pending_items.insert(pending_items.size(), d);
  endfunction

  function automatic void push_status(input idsd_pkg::kind_t k);
    decoded_t d;
    d = '0;
    d.kind = k;
    enqueue_item(d);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    int size;
    int base;
    logic [23:0] c;
    logic [7:0] st;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] bl;
    logic [7:0] mx;
    decoded_t d;
    if (m_halted) return;
    if (m_phase == idsd_pkg::PHASE_HEADER) begin
      if (m_idx < 4 && b != idsd_pkg::SIGNATURE[m_idx]) m_sig_ok = 1'b0;
      if (m_idx == 7) begin
        m_fmt = b[2:0];
        m_fmt_known = (b == 0 || b == 1 || b == 2 || b == 4 || b == 5);
      end
      if (m_idx == 24) m_left[15:8] = b;
      if (m_idx == 25) m_left[7:0] = b;
      if (m_idx == 30) m_slot = b % NPROJ;
      if (m_idx < idsd_pkg::HDR_LAST) begin
        m_idx++;
        return;
      end
      m_idx = 0;
      if (!m_sig_ok) begin
        m_halted = 1'b1;
        push_status(idsd_pkg::KIND_BAD_SIG);
      end else if (m_left == 0) begin
        m_sig_ok = 1'b1;
        push_status(idsd_pkg::KIND_EOF);
      end else if (!m_fmt_known) begin
        m_halted = 1'b1;
        push_status(idsd_pkg::KIND_BAD_FMT);
      end else begin
        m_pal_idx = 0;
        m_phase = (m_fmt == idsd_pkg::FMT_PALETTE) ? idsd_pkg::PHASE_PALETTE
                                                   : idsd_pkg::PHASE_POINTS;
      end
      return;
    end
    size = record_size_of(m_fmt);
    if (m_idx < 10) m_rec[m_idx] = b;
    m_idx++;
    if (m_idx < size) return;
    m_idx = 0;
    if (m_phase == idsd_pkg::PHASE_PALETTE) begin
      if (m_pal_idx < 256) begin
        m_palette[m_slot*256+m_pal_idx] = {m_rec[0], m_rec[1], m_rec[2]};
        m_pal_idx++;
      end
    end else begin
      if (m_fmt == idsd_pkg::FMT_3D_INDEXED || m_fmt == idsd_pkg::FMT_2D_INDEXED) begin
        base = (m_fmt == idsd_pkg::FMT_3D_INDEXED) ? 6 : 4;
        c = m_palette[m_slot*256 + m_rec[base+1]];
        st = m_rec[base];
        {r, g, bl} = c;
      end else begin
        base = (m_fmt == idsd_pkg::FMT_3D_TRUE) ? 6 : 4;
        st = m_rec[base];
        bl = m_rec[base+1];
        g = m_rec[base+2];
        r = m_rec[base+3];
      end
      d = '0;
      d.kind = idsd_pkg::KIND_POINT;
      d.x_pos = to_screen(m_rec[0], m_rec[1]);
      d.y_pos = to_screen(m_rec[2], m_rec[3]);
      if (!st[6]) begin
        mx = (r > g) ? r : g;
        if (bl > mx) mx = bl;
        d.red = r;
        d.green = g;
        d.blue = bl;
        d.intensity = mx;
      end
      d.last = (m_left == 16'd1);
      enqueue_item(d);
    end
    m_left = m_left - 16'd1;
    if (m_left == 0) m_phase = idsd_pkg::PHASE_HEADER;
  endfunction

  // sender: hold valid across back-to-back items, drop it only in a gap
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b);
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    decoded_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_items.size() == 0) begin
        report("unexpected item kind", out_ch.kind, -1);
      end else begin
        w = pending_items.pop_front();
        if (out_ch.kind != w.kind) report("kind", out_ch.kind, w.kind);
        if (out_ch.x_pos != w.x_pos) report("x_pos", out_ch.x_pos, w.x_pos);
        if (out_ch.y_pos != w.y_pos) report("y_pos", out_ch.y_pos, w.y_pos);
        if (out_ch.red != w.red) report("red", out_ch.red, w.red);
        if (out_ch.green != w.green) report("green", out_ch.green, w.green);
        if (out_ch.blue != w.blue) report("blue", out_ch.blue, w.blue);
        if (out_ch.intensity != w.intensity) report("intensity", out_ch.intensity, w.intensity);
        if (out_ch.last_in_section != w.last)
          report("last_in_section", out_ch.last_in_section, w.last);
      end
    end
  end

  task automatic send_header(input logic [7:0] fmt, input logic [15:0] count,
                             input logic [7:0] proj, input logic bad_sig);
    logic [7:0] b;
    for (int i = 0; i < 32; i++) begin
      b = 8'($urandom_range(255));
      if (i < 4) begin
        b = idsd_pkg::SIGNATURE[i];
        if (bad_sig && i == $unsigned(count) % 4) b = b ^ (8'h1 << $urandom_range(7));
      end
      if (i == 7) b = fmt;
      if (i == 24) b = count[15:8];
      if (i == 25) b = count[7:0];
      if (i == 30) b = proj;
      send_byte(b);
    end
  endtask

  // one point record from explicit fields, with a random z for 3D formats
  task automatic send_point(input logic [2:0] fmt, input logic [15:0] x, input logic [15:0] y,
                            input logic [7:0] status, input logic [23:0] colour);
    logic [7:0] rec [10];
    int n;
    rec[0] = x[15:8];
    rec[1] = x[7:0];
    rec[2] = y[15:8];
    rec[3] = y[7:0];
    n = 4;
    if (fmt == idsd_pkg::FMT_3D_INDEXED || fmt == idsd_pkg::FMT_3D_TRUE) begin
      rec[4] = 8'($urandom_range(255));
      rec[5] = 8'($urandom_range(255));
      n = 6;
    end
    rec[n] = status;
    n = n + 1;
    if (fmt == idsd_pkg::FMT_3D_INDEXED || fmt == idsd_pkg::FMT_2D_INDEXED) begin
      rec[n] = colour[7:0];
      n = n + 1;
    end else begin
      rec[n] = colour[7:0];
      rec[n+1] = colour[15:8];
      rec[n+2] = colour[23:16];
      n = n + 3;
    end
    for (int i = 0; i < n; i++) send_byte(rec[i]);
  endtask

  task automatic send_random_section(input logic [2:0] fmt, input int count,
                                     input logic [7:0] proj);
    logic [15:0] x;
    logic [15:0] y;
    send_header({5'd0, fmt}, count[15:0], proj, 1'b0);
    for (int k = 0; k < count; k++) begin
      if (fmt == idsd_pkg::FMT_PALETTE) begin
        for (int i = 0; i < 3; i++) send_byte(8'($urandom_range(255)));
      end else begin
        x = 16'($urandom_range(65535));
        y = 16'($urandom_range(65535));
        if ($urandom_range(9) == 0) x = 16'(16'h7FF8 + $urandom_range(15));
        if ($urandom_range(9) == 0) y = 16'(16'h8000 + $urandom_range(15));
        send_point(fmt, x, y, 8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
      end
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_items.size() != 0 || guard < 8) && guard < 20000) begin
      @(posedge clk);
      if (pending_items.size() == 0) guard++;
    end
  endtask

  task automatic test_default_palette();
    send_header({5'd0, idsd_pkg::FMT_3D_INDEXED}, 16'd8, 8'd0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_point(idsd_pkg::FMT_3D_INDEXED, 16'd0, 16'd0, (i == 3) ? 8'h40 : 8'h00,
                 24'(i * 36 + 3));
  endtask

  task automatic test_coord_extremes();
    send_header({5'd0, idsd_pkg::FMT_2D_TRUE}, 16'd6, 8'd2, 1'b0);
    send_point(idsd_pkg::FMT_2D_TRUE, 16'h8000, 16'h7FFF, 8'h00, 24'hFFFFFF);
    send_point(idsd_pkg::FMT_2D_TRUE, 16'hFFF8, 16'h0008, 8'h00, 24'h000000);
    send_point(idsd_pkg::FMT_2D_TRUE, 16'h0007, 16'hFFF9, 8'hFF, 24'h123456);
    send_point(idsd_pkg::FMT_2D_TRUE, 16'h7FF8, 16'h8008, 8'hBF, 24'h80FF01);
    send_point(idsd_pkg::FMT_2D_TRUE, 16'h0000, 16'hFFFF, 8'h00, 24'h00FF00);
    send_point(idsd_pkg::FMT_2D_TRUE, 16'h0018, 16'hFFE8, 8'h00, 24'h0000FF);
  endtask

  task automatic test_palette_load();
    // projector 5 maps to slot 1
    send_random_section(idsd_pkg::FMT_PALETTE, 12, 8'd5);
    send_header({5'd0, idsd_pkg::FMT_2D_INDEXED}, 16'd6, 8'd1, 1'b0);
    for (int i = 0; i < 6; i++)
      send_point(idsd_pkg::FMT_2D_INDEXED, 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), 8'h00, 24'(i * 2));
    send_random_section(idsd_pkg::FMT_3D_TRUE, 3, 8'd255);
  endtask

  task automatic test_long_palette();
    send_random_section(idsd_pkg::FMT_PALETTE, 260, 8'd3);
    send_random_section(idsd_pkg::FMT_3D_INDEXED, 5, 8'd7);
  endtask

  task automatic test_end_of_file();
    send_header(8'd3, 16'd0, 8'd0, 1'b0);
    send_header(8'd0, 16'd0, 8'd9, 1'b0);
    send_random_section(idsd_pkg::FMT_2D_INDEXED, 2, 8'd0);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_gap_pct = 0; recv_stall_pct = 0; end
      1: begin send_gap_pct = 47; recv_stall_pct = 0; end
      2: begin send_gap_pct = 0; recv_stall_pct = 47; end
      default: begin send_gap_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  task automatic test_random_files();
    int sent;
    int sect;
    int pick;
    logic [2:0] fmt;
    sent = 0;
    sect = 0;
    while (sent < 400 || sect < 4) begin
      set_idling(sect);
      pick = $urandom_range(9);
      fmt = (pick < 3) ? idsd_pkg::FMT_3D_INDEXED : (pick < 5) ? idsd_pkg::FMT_2D_INDEXED :
            (pick < 7) ? idsd_pkg::FMT_3D_TRUE : (pick < 9) ? idsd_pkg::FMT_2D_TRUE :
            idsd_pkg::FMT_PALETTE;
      if ($urandom_range(11) == 0) begin
        send_header(8'($urandom_range(255)), 16'd0, 8'($urandom_range(255)), 1'b0);
        sent += 32;
      end else begin
        pick = $urandom_range(1, 8);
        send_random_section(fmt, pick, 8'($urandom_range(255)));
        sent += 32 + pick * record_size_of(fmt);
      end
      sect++;
    end
    set_idling(0);
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    send_random_section(idsd_pkg::FMT_2D_TRUE, 20, 8'd1);
  endtask

  task automatic test_halt();
    if ($urandom_range(1) == 1) send_header({5'd0, idsd_pkg::FMT_2D_TRUE}, 16'd4, 8'd0, 1'b1);
    else send_header(8'd6 + 8'($urandom_range(1)) * 8'd1, 16'd3, 8'd0, 1'b0);
    // ignored after the error
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    reset_mirror();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_palette();
    test_coord_extremes();
    test_palette_load();
    test_long_palette();
    test_end_of_file();
    test_random_files();
    test_backpressure();
    set_idling(3);
    test_halt();
    idle_sender();
    wait_drained();
    if (errors == 0 && pending_items.size() == 0) begin
      $display("[ilda_stream_decoder_top] OK");
    end else begin
      $display("[ilda_stream_decoder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[ilda_stream_decoder_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/idsd_pkg.sv
hdl/idsd_in_if.sv
hdl/idsd_out_if.sv
hdl/idsd_parse.sv
hdl/idsd_pal.sv
hdl/ilda_stream_decoder_top.sv
verif/tb_ilda_stream_decoder_top.sv
